[hw/rtl/cff_pkg.sv]
// ----------------------------------------------------------------------------
// cff_pkg
// Shared constants, request codes and control types of the complex FIR filter.
// ----------------------------------------------------------------------------
package cff_pkg;

  localparam int CFF_MAX_TAPS     = 128;
  localparam int CFF_SAMPLE_WIDTH = 16;
  localparam int CFF_COEF_WIDTH   = 16;

  localparam int ACC_W        = 64;
  localparam int REQ_W        = 2;
  localparam int COEF_INDEX_W = 7;
  localparam int TAP_CFG_W    = 8;

  localparam logic [TAP_CFG_W-1:0] TAP_COUNT_RESET = 8'd128;

  localparam logic [REQ_W-1:0] REQ_FILTER = 2'd0;
  localparam logic [REQ_W-1:0] REQ_LOAD   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_DONE
  } fsm_state_t;

  typedef struct packed {
    logic clr;
    logic vld;
  } mac_ctl_t;

  typedef struct packed {
    logic busy;
  } mac_stat_t;

endpackage

[hw/rtl/cff_if.sv]
// ----------------------------------------------------------------------------
// cff_if
// Valid/ready channels of the complex FIR filter: request beats and results.
// ----------------------------------------------------------------------------
interface cff_in_if import cff_pkg::*; #(
  parameter int SAMPLE_WIDTH = CFF_SAMPLE_WIDTH,
  parameter int COEF_WIDTH   = CFF_COEF_WIDTH
) ();
  logic                           valid;
  logic                           ready;
  logic [REQ_W-1:0]               req_type;
  logic signed [SAMPLE_WIDTH-1:0] sample_i;
  logic signed [SAMPLE_WIDTH-1:0] sample_q;
  logic [COEF_INDEX_W-1:0]        coef_index;
  logic signed [COEF_WIDTH-1:0]   coef_value;
  logic                           in_last;

  modport source (
    output valid, req_type, sample_i, sample_q, coef_index, coef_value, in_last,
    input  ready
  );
  modport sink (
    input  valid, req_type, sample_i, sample_q, coef_index, coef_value, in_last,
    output ready
  );
endinterface

interface cff_out_if import cff_pkg::*; #(
  parameter int SAMPLE_WIDTH = CFF_SAMPLE_WIDTH
) ();
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] out_i;
  logic signed [SAMPLE_WIDTH-1:0] out_q;
  logic                           saturated;
  logic                           out_last;

  modport source (
    output valid, out_i, out_q, saturated, out_last,
    input  ready
  );
  modport sink (
    input  valid, out_i, out_q, saturated, out_last,
    output ready
  );
endinterface

[hw/rtl/cff_mac.sv]
// ----------------------------------------------------------------------------
// cff_mac
// Multiply-accumulate for I and Q on one shared coefficient, with rounding and saturation.
// ----------------------------------------------------------------------------
module cff_mac import cff_pkg::*; #(
  parameter int SAMPLE_WIDTH = CFF_SAMPLE_WIDTH,
  parameter int COEF_WIDTH   = CFF_COEF_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  mac_ctl_t                       ctl,
  input  logic signed [SAMPLE_WIDTH-1:0] smp_i,
  input  logic signed [SAMPLE_WIDTH-1:0] smp_q,
  input  logic signed [COEF_WIDTH-1:0]   coef,
  output mac_stat_t                      stat,
  output logic signed [SAMPLE_WIDTH-1:0] res_i,
  output logic signed [SAMPLE_WIDTH-1:0] res_q,
  output logic                           res_sat
);

  localparam int PROD_W = SAMPLE_WIDTH + COEF_WIDTH;
  localparam int FRAC_W = COEF_WIDTH - 1;
  localparam logic signed [ACC_W-1:0] RND_ONE = ACC_W'(64'd1 << (FRAC_W - 1));
  localparam logic signed [ACC_W-1:0] SAT_HI  =
    ACC_W'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1);
  localparam logic signed [ACC_W-1:0] SAT_LO  = ~SAT_HI;

  logic                     p_v_r;
  logic signed [PROD_W-1:0] prod_i_r;
  logic signed [PROD_W-1:0] prod_q_r;
  logic signed [ACC_W-1:0]  acc_i_r;
  logic signed [ACC_W-1:0]  acc_q_r;
  logic [SAMPLE_WIDTH:0]    rs_i;
  logic [SAMPLE_WIDTH:0]    rs_q;

  // returns {clip, value}
  function automatic logic [SAMPLE_WIDTH:0] round_sat(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0] rnd;
    logic signed [ACC_W-1:0] shf;
    logic [SAMPLE_WIDTH:0]   res;
    rnd = acc + RND_ONE;
    shf = rnd >>> FRAC_W;
    if (shf > SAT_HI) begin
      res = {1'b1, SAT_HI[SAMPLE_WIDTH-1:0]};
    end else if (shf < SAT_LO) begin
      res = {1'b1, SAT_LO[SAMPLE_WIDTH-1:0]};
    end else begin
      res = {1'b0, shf[SAMPLE_WIDTH-1:0]};
    end
    return res;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_v_r <= 1'b0;
    end else begin
      p_v_r <= ctl.vld;
    end
  end

  always_ff @(posedge clk) begin
    prod_i_r <= smp_i * coef;
    prod_q_r <= smp_q * coef;
    if (ctl.clr) begin
      acc_i_r <= '0;
      acc_q_r <= '0;
    end else if (p_v_r) begin
      acc_i_r <= acc_i_r + ACC_W'(prod_i_r);
      acc_q_r <= acc_q_r + ACC_W'(prod_q_r);
    end
  end

  assign stat.busy = p_v_r;

  assign rs_i    = round_sat(acc_i_r);
  assign rs_q    = round_sat(acc_q_r);
  assign res_i   = rs_i[SAMPLE_WIDTH-1:0];
  assign res_q   = rs_q[SAMPLE_WIDTH-1:0];
  assign res_sat = rs_i[SAMPLE_WIDTH] | rs_q[SAMPLE_WIDTH];

endmodule

[hw/rtl/complex_fir_filter_unit.sv]
// ----------------------------------------------------------------------------
// complex_fir_filter_unit
// Real-coefficient FIR over complex I/Q samples, one shared MAC per sample.
// ----------------------------------------------------------------------------
// in_ch carries request beats: filter a sample, load one coefficient, or
// clear the sample history. Only a filter beat makes a result beat on out_ch,
// holding the rounded, saturated I/Q sum, a clip flag and the copied last mark.
// cfg_we/cfg_data set the tap count; write it only while the unit is idle.
// Coefficients and the sample history sit in single-port synchronous RAMs.
// A filter beat writes the sample, then reads one tap per cycle through the
// MAC; the result is registered once the MAC has drained and out_ch can take
// it, and the next beat is taken only after that load.
// Load, clear and unknown beats leave the unit idle and ready for the next beat.
// Reset empties the history (per-slot valid bits), sets the tap count to 128
// and leaves coefficients undefined until loaded.
// The result register frees in_ch: new beats are taken while a result waits;
// a filter run that finishes while out_ch stalls holds until the beat leaves.
// ----------------------------------------------------------------------------
module complex_fir_filter_unit import cff_pkg::*; #(
  parameter int MAX_TAPS     = CFF_MAX_TAPS,
  parameter int SAMPLE_WIDTH = CFF_SAMPLE_WIDTH,
  parameter int COEF_WIDTH   = CFF_COEF_WIDTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  cff_in_if.sink               in_ch,
  cff_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [TAP_CFG_W-1:0] cfg_data
);

  localparam int ADDR_W = $clog2(MAX_TAPS);
  localparam logic [ADDR_W-1:0] LAST_SLOT = ADDR_W'(MAX_TAPS - 1);

  fsm_state_t state_r;
  fsm_state_t state_nxt;

  logic [TAP_CFG_W-1:0] tap_count_r;
  logic [ADDR_W-1:0]    wptr_r;
  logic [ADDR_W-1:0]    slot_r;
  logic [ADDR_W-1:0]    caddr_r;
  logic [MAX_TAPS-1:0]  hvld_r;

  logic [2*SAMPLE_WIDTH-1:0] hist_mem [MAX_TAPS];
  logic [COEF_WIDTH-1:0]     coef_mem [MAX_TAPS];
  logic [2*SAMPLE_WIDTH-1:0] hist_rd_r;
  logic [COEF_WIDTH-1:0]     coef_rd_r;
  logic                      rd_hvld_r;
  logic                      rd_v_r;
  logic                      last_r;

  logic                           out_v_r;
  logic signed [SAMPLE_WIDTH-1:0] out_i_r;
  logic signed [SAMPLE_WIDTH-1:0] out_q_r;
  logic                           sat_r;
  logic                           out_last_r;

  logic              in_ready;
  logic              issue;
  logic              out_load;
  logic              accept;
  logic              hist_we;
  logic              coef_we;
  logic              hist_clr;
  logic [ADDR_W-1:0] taps_m1;

  mac_ctl_t                       mac_ctl;
  mac_stat_t                      mac_stat;
  logic signed [SAMPLE_WIDTH-1:0] smp_i;
  logic signed [SAMPLE_WIDTH-1:0] smp_q;
  logic signed [SAMPLE_WIDTH-1:0] res_i;
  logic signed [SAMPLE_WIDTH-1:0] res_q;
  logic                           res_sat;

  // request decode
  assign accept = in_ch.valid && in_ready;
  always_comb begin
    hist_we  = 1'b0;
    coef_we  = 1'b0;
    hist_clr = 1'b0;
    if (accept) begin
      unique case (in_ch.req_type)
        REQ_FILTER: hist_we  = 1'b1;
        REQ_LOAD:   coef_we  = 32'(in_ch.coef_index) < 32'(MAX_TAPS);
        REQ_CLEAR:  hist_clr = 1'b1;
        default:    ;
      endcase
    end
  end

  // effective taps minus one
  always_comb begin
    if (tap_count_r == '0) begin
      taps_m1 = '0;
    end else if (32'(tap_count_r) > 32'(MAX_TAPS)) begin
      taps_m1 = LAST_SLOT;
    end else begin
      taps_m1 = ADDR_W'(tap_count_r - 8'd1);
    end
  end

  // fsm next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (hist_we) state_nxt = ST_RUN;
      ST_RUN:   if (caddr_r == '0) state_nxt = ST_DRAIN;
      ST_DRAIN: if (!rd_v_r && !mac_stat.busy) state_nxt = ST_DONE;
      ST_DONE:  if (out_load) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // fsm outputs
  always_comb begin
    in_ready = 1'b0;
    issue    = 1'b0;
    out_load = 1'b0;
    unique case (state_r)
      ST_IDLE: in_ready = 1'b1;
      ST_RUN:  issue    = 1'b1;
      ST_DONE: out_load = !out_v_r || out_ch.ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      tap_count_r <= TAP_COUNT_RESET;
      wptr_r      <= '0;
      hvld_r      <= '0;
      rd_v_r      <= 1'b0;
      out_v_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rd_v_r  <= issue;
      if (cfg_we) begin
        tap_count_r <= cfg_data;
      end
      if (hist_clr) begin
        wptr_r <= '0;
        hvld_r <= '0;
      end else if (hist_we) begin
        wptr_r         <= (wptr_r == LAST_SLOT) ? '0 : wptr_r + 1'b1;
        hvld_r[wptr_r] <= 1'b1;
      end
      if (out_load) begin
        out_v_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // tap walk: history slot goes back from newest, coefficient address down to 0
  always_ff @(posedge clk) begin
    if (hist_we) begin
      slot_r  <= wptr_r;
      caddr_r <= taps_m1;
      last_r  <= in_ch.in_last;
    end else if (issue) begin
      slot_r  <= (slot_r == '0) ? LAST_SLOT : slot_r - 1'b1;
      caddr_r <= caddr_r - 1'b1;
    end
  end

  // sample history ram
  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist_mem[wptr_r] <= {in_ch.sample_i, in_ch.sample_q};
    end
    if (issue) begin
      hist_rd_r <= hist_mem[slot_r];
      rd_hvld_r <= hvld_r[slot_r];
    end
  end

  // coefficient ram
  always_ff @(posedge clk) begin
    if (coef_we) begin
      coef_mem[ADDR_W'(in_ch.coef_index)] <= in_ch.coef_value;
    end
    if (issue) begin
      coef_rd_r <= coef_mem[caddr_r];
    end
  end

  // slots not written since reset or clear read as zero
  assign smp_i = rd_hvld_r ? hist_rd_r[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH] : '0;
  assign smp_q = rd_hvld_r ? hist_rd_r[SAMPLE_WIDTH-1:0] : '0;

  assign mac_ctl.clr = hist_we;
  assign mac_ctl.vld = rd_v_r;

  cff_mac #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .COEF_WIDTH   (COEF_WIDTH)
  ) u_mac (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (mac_ctl),
    .smp_i   (smp_i),
    .smp_q   (smp_q),
    .coef    (coef_rd_r),
    .stat    (mac_stat),
    .res_i   (res_i),
    .res_q   (res_q),
    .res_sat (res_sat)
  );

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_i_r    <= res_i;
      out_q_r    <= res_q;
      sat_r      <= res_sat;
      out_last_r <= last_r;
    end
  end

  assign in_ch.ready      = in_ready;
  assign out_ch.valid     = out_v_r;
  assign out_ch.out_i     = out_i_r;
  assign out_ch.out_q     = out_q_r;
  assign out_ch.saturated = sat_r;
  assign out_ch.out_last  = out_last_r;

  a_rd_after_run: assert property (@(posedge clk) disable iff (!rst_n)
    rd_v_r |-> $past(state_r == ST_RUN))
    else $error("tap read without a run cycle");

  a_done_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE) |-> (!rd_v_r && !mac_stat.busy))
    else $error("result taken before the mac drained");

  a_filter_starts_run: assert property (@(posedge clk) disable iff (!rst_n)
    hist_we |=> (state_r == ST_RUN))
    else $error("filter beat did not start a tap walk");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (hist_we || coef_we || hist_clr) |-> !issue && !rd_v_r && !mac_stat.busy)
    else $error("memory write during a tap walk");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (!out_v_r || out_ch.ready))
    else $error("result register overwritten");

endmodule
